// ----- rtl/core/tsvs_pkg.sv -----
// package: constants, parse phase codes and shared types for the video stream stripper
package tsvs_pkg;

    localparam int PacketBytes   = 188;
    localparam int PmtPidSlots   = 16;
    localparam int VideoPidSlots = 16;

    localparam logic [7:0]  SyncByte  = 8'h47;
    localparam logic [7:0]  TidPmt    = 8'h02;
    localparam logic [7:0]  TidStop   = 8'hFF;
    localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
    localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;

    // parse phases
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_AFLEN     = 5'd1,
        PH_AFSKIP    = 5'd2,
        PH_PAT_PTR   = 5'd3,
        PH_PAT_PSKIP = 5'd4,
        PH_PAT_TID   = 5'd5,
        PH_PAT_HDR   = 5'd6,
        PH_PAT_ENTRY = 5'd7,
        PH_PMT_PTR   = 5'd8,
        PH_PMT_PSKIP = 5'd9,
        PH_TID       = 5'd10,
        PH_OTH_LEN   = 5'd11,
        PH_OTH_SKIP  = 5'd12,
        PH_PMT_HDR   = 5'd13,
        PH_PINFO     = 5'd14,
        PH_ES_TYPE   = 5'd15,
        PH_ES_HDR    = 5'd16,
        PH_ES_INFO   = 5'd17,
        PH_CRC       = 5'd18
    } t_phase;

    // table lookup and update requests between core and pid tables
    typedef struct packed {
        logic        pmt_add;
        logic        vid_add;
        logic [12:0] add_pid;
        logic [12:0] look_pid;
    } t_tab_req;

    typedef struct packed {
        logic in_pmt;
        logic in_vid;
    } t_tab_rsp;

    // one byte step of crc32/mpeg2
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic is_video_type(input logic [7:0] b);
        logic r;
        unique case (b)
            8'h01, 8'h02, 8'h10, 8'h1B, 8'h20, 8'h21,
            8'h24, 8'h42, 8'hD1, 8'hD2, 8'hEA: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/tsvs_pid_tables.sv -----
// pmt and video pid sets with parallel compare and first free slot insert
module tsvs_pid_tables (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsvs_pkg::t_tab_req i_req,
    output tsvs_pkg::t_tab_rsp o_rsp
);
    logic [tsvs_pkg::PmtPidSlots-1:0]   r_pmt_v;
    logic [12:0]                        r_pmt_pid [tsvs_pkg::PmtPidSlots];
    logic [tsvs_pkg::VideoPidSlots-1:0] r_vid_v;
    logic [12:0]                        r_vid_pid [tsvs_pkg::VideoPidSlots];

    logic [tsvs_pkg::PmtPidSlots-1:0]   pmt_hit_look, pmt_hit_add, pmt_free;
    logic [tsvs_pkg::VideoPidSlots-1:0] vid_hit_look, vid_hit_add, vid_free;

    // parallel compares and first free slot one-hot
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < tsvs_pkg::PmtPidSlots; i++) begin
            pmt_hit_look[i] = r_pmt_v[i] && (r_pmt_pid[i] == i_req.look_pid);
            pmt_hit_add[i]  = r_pmt_v[i] && (r_pmt_pid[i] == i_req.add_pid);
            pmt_free[i]     = !r_pmt_v[i] && !seen;
            if (!r_pmt_v[i]) seen = 1'b1;
        end
    end

    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < tsvs_pkg::VideoPidSlots; i++) begin
            vid_hit_look[i] = r_vid_v[i] && (r_vid_pid[i] == i_req.look_pid);
            vid_hit_add[i]  = r_vid_v[i] && (r_vid_pid[i] == i_req.add_pid);
            vid_free[i]     = !r_vid_v[i] && !seen;
            if (!r_vid_v[i]) seen = 1'b1;
        end
    end

    assign o_rsp.in_pmt = |pmt_hit_look;
    assign o_rsp.in_vid = |vid_hit_look;

    // insert when absent and a slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmt_v <= '0;
            r_vid_v <= '0;
        end else begin
            for (int i = 0; i < tsvs_pkg::PmtPidSlots; i++) begin
                if (i_req.pmt_add && !(|pmt_hit_add) && pmt_free[i]) begin
                    r_pmt_v[i] <= 1'b1;
                end
            end
            for (int i = 0; i < tsvs_pkg::VideoPidSlots; i++) begin
                if (i_req.vid_add && !(|vid_hit_add) && vid_free[i]) begin
                    r_vid_v[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tsvs_pkg::PmtPidSlots; i++) begin
            if (i_req.pmt_add && !(|pmt_hit_add) && pmt_free[i]) begin
                r_pmt_pid[i] <= i_req.add_pid;
            end
        end
        for (int i = 0; i < tsvs_pkg::VideoPidSlots; i++) begin
            if (i_req.vid_add && !(|vid_hit_add) && vid_free[i]) begin
                r_vid_pid[i] <= i_req.add_pid;
            end
        end
    end
endmodule

// ----- rtl/core/tsvs_out_queue.sv -----
// output buffer of three result bytes: takes a pair and gives one per cycle unless stalled
module tsvs_out_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_cnt,
    input  logic [9:0] i_r0,
    input  logic [9:0] i_r1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [9:0] o_head
);
    logic [9:0] r_q [3];
    logic [1:0] r_n;
    logic [9:0] n_q [3];
    logic [1:0] n_n;
    logic [2:0] tmp;

    assign o_valid = (r_n != 2'd0);
    assign o_head  = r_q[0];
    // room for two more even when nothing leaves this cycle
    assign o_room  = (r_n <= 2'd1);

    // pop then push
    always_comb begin
        logic [1:0] k;
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        n_q[2] = r_q[2];
        k = r_n;
        if (o_valid && !i_stall) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            k = r_n - 2'd1;
        end
        if (i_cnt != 2'd0) begin
            n_q[k[0] ? 1 : (k[1] ? 2 : 0)] = i_r0;
        end
        if (i_cnt == 2'd2) begin
            if (k == 2'd0) n_q[1] = i_r1;
            else n_q[2] = i_r1;
        end
        tmp = {1'b0, k} + {1'b0, i_cnt};
        n_n = tmp[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_n <= 2'd0;
        else r_n <= n_n;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end
endmodule

// ----- rtl/core/ts_video_stream_stripper.sv -----
// top level: transport stream video stripper with pmt rewrite and crc regeneration
//
// Input channel: i_data_byte / i_packet_start with i_valid, stalled by o_stall.
// Output channel: o_out_byte / o_last_of_run / o_filter_active with o_valid,
// stalled by i_stall. A request on the input causes zero, one or two output
// requests (header byte 1 gives none; it leaves together with byte 2).
// Config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes filter_enable.
// Each byte is parsed combinationally against the registered parser state;
// results enter a three-entry output buffer and leave one per cycle unless
// i_stall holds them. Throughput is one byte per cycle while outputs are
// taken, except that a step giving two results occupies the buffer and
// the input stalls while the buffer cannot absorb a pair.
// Reset (synchronous, active low) sets filtering live and enabled, empties both
// pid tables and the buffer. When the receiver stalls the buffer fills and
// o_stall rises; no byte is lost.
module ts_video_stream_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_start,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_filter_active,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    logic         r_en, r_live, r_seen;
    logic [7:0]   r_off;
    logic [2:0]   r_flags;
    logic [12:0]  r_pid;
    logic [7:0]   r_held;
    logic         r_null;
    tsvs_pkg::t_phase r_ph;
    logic [7:0]   r_skip;
    logic [11:0]  r_sec;
    logic [9:0]   r_es;
    logic [7:0]   r_fs;
    logic         r_strip;
    logic [31:0]  r_crc;

    logic         n_live, n_seen;
    logic [7:0]   n_off;
    logic [2:0]   n_flags;
    logic [12:0]  n_pid;
    logic [7:0]   n_held;
    logic         n_null;
    tsvs_pkg::t_phase n_ph;
    logic [7:0]   n_skip;
    logic [11:0]  n_sec;
    logic [9:0]   n_es;
    logic [7:0]   n_fs;
    logic         n_strip;
    logic [31:0]  n_crc;

    logic         acc;
    logic         room;
    logic [1:0]   cnt;
    logic [7:0]   e0, e1;
    tsvs_pkg::t_tab_req treq;
    tsvs_pkg::t_tab_rsp trsp;
    logic [9:0]   r0, r1, head;
    logic         act;

    assign o_stall     = !room;
    assign acc         = i_valid && room;
    assign o_cfg_ready = 1'b1;

    tsvs_pid_tables u_tab (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (treq),
        .o_rsp  (trsp)
    );

    // per-byte parse and rewrite
    always_comb begin
        logic        b_start, held, cont2, pusi;
        logic [7:0]  b, o;
        logic [11:0] v;
        logic [12:0] curpid;
        logic        doparse;
        logic [1:0]  k;
        logic [7:0]  off1;
        b = i_data_byte;
        n_live = r_live; n_seen = r_seen; n_off = r_off;
        n_flags = r_flags; n_pid = r_pid; n_held = r_held; n_null = r_null;
        n_ph = r_ph; n_skip = r_skip; n_sec = r_sec; n_es = r_es; n_fs = r_fs;
        n_strip = r_strip; n_crc = r_crc;
        cnt = 2'd0; e0 = 8'd0; e1 = 8'd0;
        treq = '0;
        v = 12'd0; o = b; pusi = r_flags[2]; doparse = 1'b0;
        off1 = 8'd0;
        curpid = {r_pid[12:8], b};
        treq.look_pid = (r_off == 8'd2) ? curpid : r_pid;
        b_start = i_packet_start || (r_seen && r_off == 8'd0);
        held = r_seen && r_off == 8'd2;
        cont2 = r_en && r_live && r_seen && !b_start && r_off == 8'd2;
        k = 2'd0;
        if (held && !cont2) begin
            e0 = r_held; k = 2'd1;
        end
        if (!r_en) begin
            n_seen = 1'b0; n_off = 8'd0; n_ph = tsvs_pkg::PH_IDLE; n_null = 1'b0;
            o = b;
        end else if (!r_live) begin
            o = b;
        end else if (b_start) begin
            n_ph = tsvs_pkg::PH_IDLE; n_null = 1'b0;
            if (b != tsvs_pkg::SyncByte) begin
                n_live = 1'b0; n_seen = 1'b0; n_off = 8'd0;
            end else begin
                n_seen = 1'b1; n_off = 8'd1; n_flags = 3'd0;
            end
            o = b;
        end else if (!r_seen) begin
            o = b;
        end else begin
            off1 = r_off + 8'd1;
            n_off = (off1 >= 8'(tsvs_pkg::PacketBytes)) ? 8'd0 : off1;
            if (r_off == 8'd1) begin
                n_held = b;
                n_flags = b[6] ? 3'd4 : 3'd0;
                n_pid = {b[4:0], 8'd0};
                k = 2'd3;
            end else if (r_off == 8'd2) begin
                n_pid = curpid;
                n_null = (curpid != 13'd0) && !(pusi && trsp.in_pmt) && trsp.in_vid;
                e0 = n_null ? 8'h1F : r_held;
                k = 2'd1;
                o = n_null ? 8'hFF : b;
            end else if (r_off == 8'd3) begin
                n_flags = r_flags | {1'b0, b[5], b[4]};
                n_ph = tsvs_pkg::PH_IDLE;
                if (r_null) o = 8'h10;
                else begin
                    o = b;
                    if ((r_pid == 13'd0 && n_flags[0]) ||
                        (pusi && n_flags[0] && trsp.in_pmt)) begin
                        if (n_flags[1]) n_ph = tsvs_pkg::PH_AFLEN;
                        else if (r_pid == 13'd0) n_ph = pusi ? tsvs_pkg::PH_PAT_PTR
                                                             : tsvs_pkg::PH_PAT_TID;
                        else n_ph = tsvs_pkg::PH_PMT_PTR;
                    end
                end
            end else if (r_null) begin
                o = (r_off == 8'd4) ? 8'h00 : 8'hFF;
            end else begin
                doparse = 1'b1;
            end
        end

        // section parser
        if (doparse) begin
            unique case (r_ph)
                tsvs_pkg::PH_AFLEN, tsvs_pkg::PH_AFSKIP: begin
                    if (r_ph == tsvs_pkg::PH_AFLEN) n_skip = b;
                    else n_skip = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
                    if (r_ph == tsvs_pkg::PH_AFSKIP ? n_skip == 8'd0 : b == 8'd0) begin
                        if (r_pid == 13'd0 && r_flags[0])
                            n_ph = r_flags[2] ? tsvs_pkg::PH_PAT_PTR : tsvs_pkg::PH_PAT_TID;
                        else n_ph = tsvs_pkg::PH_PMT_PTR;
                    end else if (r_ph == tsvs_pkg::PH_AFLEN) n_ph = tsvs_pkg::PH_AFSKIP;
                end
                tsvs_pkg::PH_PAT_PTR: begin
                    n_skip = b;
                    n_ph = (b != 8'd0) ? tsvs_pkg::PH_PAT_PSKIP : tsvs_pkg::PH_PAT_TID;
                end
                tsvs_pkg::PH_PMT_PTR: begin
                    n_skip = b;
                    n_ph = (b != 8'd0) ? tsvs_pkg::PH_PMT_PSKIP : tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PAT_PSKIP, tsvs_pkg::PH_PMT_PSKIP: begin
                    n_skip = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
                    if (n_skip == 8'd0)
                        n_ph = (r_ph == tsvs_pkg::PH_PAT_PSKIP) ? tsvs_pkg::PH_PAT_TID
                                                               : tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PAT_TID: begin
                    if (b == tsvs_pkg::TidStop) n_ph = tsvs_pkg::PH_IDLE;
                    else begin
                        n_ph = tsvs_pkg::PH_PAT_HDR; n_skip = 8'd1;
                    end
                end
                tsvs_pkg::PH_PAT_HDR: begin
                    if (r_skip == 8'd1) n_fs = b;
                    else if (r_skip == 8'd2) begin
                        v = {r_fs[3:0], b};
                        n_sec = (v >= 12'd9) ? v - 12'd9 : 12'd0;
                    end
                    if (r_skip >= 8'd7) begin
                        n_ph = (n_sec >= 12'd4) ? tsvs_pkg::PH_PAT_ENTRY : tsvs_pkg::PH_IDLE;
                        n_skip = 8'd0;
                    end else n_skip = r_skip + 8'd1;
                end
                tsvs_pkg::PH_PAT_ENTRY: begin
                    if (r_skip == 8'd0 || r_skip == 8'd2) n_fs = b;
                    else if (r_skip == 8'd1) n_strip = (r_fs | b) != 8'd0;
                    else if (r_strip) begin
                        treq.pmt_add = 1'b1;
                        treq.add_pid = {r_fs[4:0], b};
                    end
                    n_sec = (r_sec != 12'd0) ? r_sec - 12'd1 : r_sec;
                    if (r_skip >= 8'd3) begin
                        n_skip = 8'd0;
                        if (n_sec < 12'd4) n_ph = tsvs_pkg::PH_IDLE;
                    end else n_skip = r_skip + 8'd1;
                end
                tsvs_pkg::PH_TID: begin
                    if (b == tsvs_pkg::TidStop) n_ph = tsvs_pkg::PH_IDLE;
                    else if (b == tsvs_pkg::TidPmt) begin
                        n_crc = tsvs_pkg::crc_step(tsvs_pkg::CrcInit, b);
                        n_ph = tsvs_pkg::PH_PMT_HDR; n_skip = 8'd1;
                    end else begin
                        n_ph = tsvs_pkg::PH_OTH_LEN; n_skip = 8'd1;
                    end
                end
                tsvs_pkg::PH_OTH_LEN: begin
                    if (r_skip == 8'd1) begin
                        n_fs = b; n_skip = 8'd2;
                    end else begin
                        n_sec = {2'b00, r_fs[1:0], b};
                        n_ph = (n_sec != 12'd0) ? tsvs_pkg::PH_OTH_SKIP : tsvs_pkg::PH_TID;
                    end
                end
                tsvs_pkg::PH_OTH_SKIP: begin
                    n_sec = (r_sec != 12'd0) ? r_sec - 12'd1 : r_sec;
                    if (n_sec == 12'd0) n_ph = tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PMT_HDR, tsvs_pkg::PH_PINFO, tsvs_pkg::PH_ES_TYPE,
                tsvs_pkg::PH_ES_HDR, tsvs_pkg::PH_ES_INFO: begin
                    logic tail;
                    tail = 1'b1;
                    if (r_ph == tsvs_pkg::PH_PMT_HDR && r_skip == 8'd1) begin
                        tail = 1'b0;
                        n_crc = tsvs_pkg::crc_step(r_crc, b);
                        n_fs = b; n_skip = 8'd2;
                    end else if (r_ph == tsvs_pkg::PH_PMT_HDR && r_skip == 8'd2) begin
                        tail = 1'b0;
                        n_crc = tsvs_pkg::crc_step(r_crc, b);
                        v = {r_fs[3:0], b};
                        if (v < 12'd4) begin
                            n_sec = v;
                            n_ph = (v != 12'd0) ? tsvs_pkg::PH_OTH_SKIP : tsvs_pkg::PH_TID;
                        end else begin
                            n_sec = v - 12'd4;
                            n_skip = 8'd3;
                            if (n_sec == 12'd0) begin
                                n_ph = tsvs_pkg::PH_CRC; n_skip = 8'd0;
                            end
                        end
                    end else if (r_ph == tsvs_pkg::PH_PMT_HDR) begin
                        if (r_skip == 8'd10) n_fs = b;
                        if (r_skip >= 8'd11) begin
                            n_es = {r_fs[1:0], b};
                            n_ph = (n_es != 10'd0) ? tsvs_pkg::PH_PINFO
                                                   : tsvs_pkg::PH_ES_TYPE;
                        end else n_skip = r_skip + 8'd1;
                    end else if (r_ph == tsvs_pkg::PH_PINFO) begin
                        n_es = (r_es != 10'd0) ? r_es - 10'd1 : r_es;
                        if (n_es == 10'd0) n_ph = tsvs_pkg::PH_ES_TYPE;
                    end else if (r_ph == tsvs_pkg::PH_ES_TYPE) begin
                        n_strip = tsvs_pkg::is_video_type(b);
                        if (n_strip) o = 8'hFF;
                        n_ph = tsvs_pkg::PH_ES_HDR; n_skip = 8'd1;
                    end else if (r_ph == tsvs_pkg::PH_ES_HDR) begin
                        if (r_skip == 8'd1 || r_skip == 8'd3) n_fs = b;
                        else if (r_skip == 8'd2) begin
                            treq.vid_add = r_strip;
                            treq.add_pid = {r_fs[4:0], b};
                        end else begin
                            n_es = {r_fs[1:0], b};
                            n_ph = (n_es != 10'd0) ? tsvs_pkg::PH_ES_INFO
                                                   : tsvs_pkg::PH_ES_TYPE;
                        end
                        if (r_skip < 8'd4) n_skip = r_skip + 8'd1;
                    end else begin
                        if (r_strip) o = 8'hFF;
                        n_es = (r_es != 10'd0) ? r_es - 10'd1 : r_es;
                        if (n_es == 10'd0) n_ph = tsvs_pkg::PH_ES_TYPE;
                    end
                    // section tail: crc and countdown
                    if (tail) begin
                        n_crc = tsvs_pkg::crc_step(r_crc, o);
                        n_sec = (r_sec != 12'd0) ? r_sec - 12'd1 : r_sec;
                        if (n_sec == 12'd0) begin
                            n_ph = tsvs_pkg::PH_CRC; n_skip = 8'd0;
                        end
                    end
                end
                tsvs_pkg::PH_CRC: begin
                    unique case (r_skip[1:0])
                        2'd0: o = r_crc[31:24];
                        2'd1: o = r_crc[23:16];
                        2'd2: o = r_crc[15:8];
                        default: o = r_crc[7:0];
                    endcase
                    if (r_skip >= 8'd3) n_ph = tsvs_pkg::PH_TID;
                    else n_skip = r_skip + 8'd1;
                end
                default: begin
                end
            endcase
        end

        // assemble results
        if (k == 2'd3) begin
            cnt = 2'd0;
        end else if (k == 2'd1) begin
            cnt = 2'd2; e1 = o;
        end else begin
            cnt = 2'd1; e0 = o;
        end
        if (!acc) begin
            cnt = 2'd0; treq.pmt_add = 1'b0; treq.vid_add = 1'b0;
        end
    end

    assign act = r_en && n_live;
    assign r0 = {e0, (cnt == 2'd1), act};
    assign r1 = {e1, 1'b1, act};

    tsvs_out_queue u_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cnt  (cnt),
        .i_r0   (r0),
        .i_r1   (r1),
        .o_room (room),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_head (head)
    );

    assign o_out_byte      = head[9:2];
    assign o_last_of_run   = head[1];
    assign o_filter_active = head[0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1; r_live <= 1'b1; r_seen <= 1'b0; r_off <= 8'd0;
            r_flags <= 3'd0; r_pid <= 13'd0; r_held <= 8'd0; r_null <= 1'b0;
            r_ph <= tsvs_pkg::PH_IDLE; r_skip <= 8'd0; r_sec <= 12'd0;
            r_es <= 10'd0; r_fs <= 8'd0; r_strip <= 1'b0; r_crc <= tsvs_pkg::CrcInit;
        end else begin
            if (i_cfg_valid) r_en <= i_cfg_data;
            if (acc) begin
                r_live <= n_live; r_seen <= n_seen; r_off <= n_off;
                r_flags <= n_flags; r_pid <= n_pid; r_held <= n_held; r_null <= n_null;
                r_ph <= n_ph; r_skip <= n_skip; r_sec <= n_sec; r_es <= n_es;
                r_fs <= n_fs; r_strip <= n_strip; r_crc <= n_crc;
            end
        end
    end

`ifndef ASSERT_OFF
    a_live_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_live |=> !r_live) else $error("filter live came back without reset");
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off < 8'(tsvs_pkg::PacketBytes)) else $error("packet offset out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> cnt == 2'd0) else $error("results pushed while stalled");
`endif
endmodule

// ----- sim/ts_video_stream_stripper_tb.sv -----
// testbench: transport stream video stripper checked against a byte-level predictor
module ts_video_stream_stripper_tb;

    typedef struct packed {
        logic [7:0] b;
        logic       ps;
    } t_in_byte;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       act;
    } t_out_byte;

    // stripper predictor and queue of expected output bytes
    class strip_scoreboard;
        t_out_byte exp_q[$];
        int        errors;
        bit        en, live, aligned, nullr, strip;
        int        off, skip, secrem, esrem, fsh;
        logic [2:0]  hflags;
        logic [12:0] pid;
        logic [7:0]  held;
        logic [31:0] crc;
        tsvs_pkg::t_phase ph;
        logic [12:0] pmt_tab[$];
        logic [12:0] vid_tab[$];
        logic [7:0]  res[$];

        function new();
            en = 1; live = 1; aligned = 0; nullr = 0; strip = 0;
            off = 0; skip = 0; secrem = 0; esrem = 0; fsh = 0;
            hflags = 0; pid = 0; held = 0; crc = '1; ph = tsvs_pkg::PH_IDLE;
            errors = 0;
        endfunction

        function bit has(ref logic [12:0] t[$], input logic [12:0] p);
            foreach (t[i]) if (t[i] == p) return 1;
            return 0;
        endfunction

        function void add(ref logic [12:0] t[$], input logic [12:0] p, input int slots);
            if (!has(t, p) && t.size() < slots) t.push_back(p);
        endfunction

        function void crc_feed(logic [7:0] b);
            crc = crc ^ {b, 24'd0};
            for (int i = 0; i < 8; i++) crc = crc[31] ? ((crc << 1) ^ 32'h04C11DB7) : (crc << 1);
        endfunction

        function tsvs_pkg::t_phase payload_ph();
            if (pid == 0 && hflags[0])
                return hflags[2] ? tsvs_pkg::PH_PAT_PTR : tsvs_pkg::PH_PAT_TID;
            return tsvs_pkg::PH_PMT_PTR;
        endfunction

        function void sec_tail(logic [7:0] o);
            crc_feed(o);
            if (secrem > 0) secrem--;
            if (secrem == 0) begin
                ph = tsvs_pkg::PH_CRC;
                skip = 0;
            end
        endfunction

        function logic [7:0] parse(logic [7:0] b);
            logic [7:0] o;
            int v;
            o = b;
            case (ph)
                tsvs_pkg::PH_AFLEN: begin
                    skip = b;
                    ph = b ? tsvs_pkg::PH_AFSKIP : payload_ph();
                end
                tsvs_pkg::PH_AFSKIP: begin
                    if (skip > 0) skip--;
                    if (skip == 0) ph = payload_ph();
                end
                tsvs_pkg::PH_PAT_PTR: begin
                    skip = b;
                    ph = b ? tsvs_pkg::PH_PAT_PSKIP : tsvs_pkg::PH_PAT_TID;
                end
                tsvs_pkg::PH_PMT_PTR: begin
                    skip = b;
                    ph = b ? tsvs_pkg::PH_PMT_PSKIP : tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PAT_PSKIP, tsvs_pkg::PH_PMT_PSKIP: begin
                    if (skip > 0) skip--;
                    if (skip == 0)
                        ph = (ph == tsvs_pkg::PH_PAT_PSKIP) ? tsvs_pkg::PH_PAT_TID
                                                            : tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PAT_TID: begin
                    if (b == tsvs_pkg::TidStop) ph = tsvs_pkg::PH_IDLE;
                    else begin
                        ph = tsvs_pkg::PH_PAT_HDR;
                        skip = 1;
                    end
                end
                tsvs_pkg::PH_PAT_HDR: begin
                    if (skip == 1) fsh = b;
                    else if (skip == 2) begin
                        v = ((fsh << 8) | b) & 'hFFF;
                        secrem = (v >= 9) ? v - 9 : 0;
                    end
                    if (skip >= 7) begin
                        ph = (secrem >= 4) ? tsvs_pkg::PH_PAT_ENTRY : tsvs_pkg::PH_IDLE;
                        skip = 0;
                    end else skip++;
                end
                tsvs_pkg::PH_PAT_ENTRY: begin
                    if (skip == 0) fsh = b;
                    else if (skip == 1) strip = ((fsh | b) != 0);
                    else if (skip == 2) fsh = b;
                    else if (strip)
                        add(pmt_tab, 13'(((fsh << 8) | b) & 'h1FFF), tsvs_pkg::PmtPidSlots);
                    if (secrem > 0) secrem--;
                    if (skip >= 3) begin
                        skip = 0;
                        if (secrem < 4) ph = tsvs_pkg::PH_IDLE;
                    end else skip++;
                end
                tsvs_pkg::PH_TID: begin
                    if (b == tsvs_pkg::TidStop) ph = tsvs_pkg::PH_IDLE;
                    else if (b == tsvs_pkg::TidPmt) begin
                        crc = '1;
                        crc_feed(b);
                        ph = tsvs_pkg::PH_PMT_HDR;
                        skip = 1;
                    end else begin
                        ph = tsvs_pkg::PH_OTH_LEN;
                        skip = 1;
                    end
                end
                tsvs_pkg::PH_OTH_LEN: begin
                    if (skip == 1) begin
                        fsh = b;
                        skip = 2;
                    end else begin
                        secrem = ((fsh << 8) | b) & 'h3FF;
                        ph = secrem ? tsvs_pkg::PH_OTH_SKIP : tsvs_pkg::PH_TID;
                    end
                end
                tsvs_pkg::PH_OTH_SKIP: begin
                    if (secrem > 0) secrem--;
                    if (secrem == 0) ph = tsvs_pkg::PH_TID;
                end
                tsvs_pkg::PH_PMT_HDR: begin
                    if (skip == 1) begin
                        crc_feed(b);
                        fsh = b;
                        skip = 2;
                    end else if (skip == 2) begin
                        crc_feed(b);
                        v = ((fsh << 8) | b) & 'hFFF;
                        if (v < 4) begin
                            secrem = v;
                            ph = v ? tsvs_pkg::PH_OTH_SKIP : tsvs_pkg::PH_TID;
                        end else begin
                            secrem = v - 4;
                            skip = 3;
                            if (secrem == 0) begin
                                ph = tsvs_pkg::PH_CRC;
                                skip = 0;
                            end
                        end
                    end else begin
                        if (skip == 10) fsh = b;
                        if (skip >= 11) begin
                            esrem = ((fsh << 8) | b) & 'h3FF;
                            ph = esrem ? tsvs_pkg::PH_PINFO : tsvs_pkg::PH_ES_TYPE;
                        end else skip++;
                        sec_tail(b);
                    end
                end
                tsvs_pkg::PH_PINFO: begin
                    if (esrem > 0) esrem--;
                    if (esrem == 0) ph = tsvs_pkg::PH_ES_TYPE;
                    sec_tail(b);
                end
                tsvs_pkg::PH_ES_TYPE: begin
                    case (b)
                        8'h01, 8'h02, 8'h10, 8'h1B, 8'h20, 8'h21,
                        8'h24, 8'h42, 8'hD1, 8'hD2, 8'hEA: begin
                            strip = 1;
                            o = 8'hFF;
                        end
                        default: strip = 0;
                    endcase
                    ph = tsvs_pkg::PH_ES_HDR;
                    skip = 1;
                    sec_tail(o);
                end
                tsvs_pkg::PH_ES_HDR: begin
                    if (skip == 1 || skip == 3) fsh = b;
                    else if (skip == 2) begin
                        if (strip)
                            add(vid_tab, 13'(((fsh << 8) | b) & 'h1FFF),
                                tsvs_pkg::VideoPidSlots);
                    end else begin
                        esrem = ((fsh << 8) | b) & 'h3FF;
                        ph = esrem ? tsvs_pkg::PH_ES_INFO : tsvs_pkg::PH_ES_TYPE;
                    end
                    if (skip < 4) skip++;
                    sec_tail(b);
                end
                tsvs_pkg::PH_ES_INFO: begin
                    if (strip) o = 8'hFF;
                    if (esrem > 0) esrem--;
                    if (esrem == 0) ph = tsvs_pkg::PH_ES_TYPE;
                    sec_tail(o);
                end
                tsvs_pkg::PH_CRC: begin
                    o = crc[31 - 8 * (skip & 3) -: 8];
                    if (skip >= 3) ph = tsvs_pkg::PH_TID;
                    else skip++;
                end
                default: ;
            endcase
            return o;
        endfunction

        function void pkt_byte(logic [7:0] b);
            if (off == 1) begin
                held = b;
                hflags = b[6] ? 3'd4 : 3'd0;
                pid = {b[4:0], 8'd0};
            end else if (off == 2) begin
                pid = pid | b;
                nullr = pid != 0 && !(hflags[2] && has(pmt_tab, pid)) && has(vid_tab, pid);
                res.push_back(nullr ? 8'h1F : held);
                res.push_back(nullr ? 8'hFF : b);
            end else if (off == 3) begin
                hflags = hflags | {1'b0, b[5], b[4]};
                ph = tsvs_pkg::PH_IDLE;
                if (nullr) res.push_back(8'h10);
                else begin
                    res.push_back(b);
                    if ((pid == 0 && hflags[0]) ||
                        (hflags[2] && hflags[0] && has(pmt_tab, pid)))
                        ph = hflags[1] ? tsvs_pkg::PH_AFLEN : payload_ph();
                end
            end else begin
                if (nullr) res.push_back(off == 4 ? 8'h00 : 8'hFF);
                else res.push_back(parse(b));
            end
            off++;
            if (off >= tsvs_pkg::PacketBytes) off = 0;
        endfunction

        // accepted input request: predict its output bytes
        function void note_input(logic [7:0] b, logic ps);
            bit start, held_now, cont2;
            t_out_byte e;
            start = ps || (aligned && off == 0);
            held_now = aligned && off == 2;
            cont2 = en && live && aligned && !start && off == 2;
            res.delete();
            if (held_now && !cont2) res.push_back(held);
            if (!en) begin
                aligned = 0; off = 0; ph = tsvs_pkg::PH_IDLE; nullr = 0;
                res.push_back(b);
            end else if (!live) res.push_back(b);
            else if (start) begin
                if (b != tsvs_pkg::SyncByte) begin
                    live = 0; aligned = 0; off = 0; ph = tsvs_pkg::PH_IDLE; nullr = 0;
                end else begin
                    aligned = 1; off = 1; hflags = 0; nullr = 0; ph = tsvs_pkg::PH_IDLE;
                end
                res.push_back(b);
            end else if (!aligned) res.push_back(b);
            else pkt_byte(b);
            foreach (res[k]) begin
                e.b = res[k];
                e.last = (k == res.size() - 1);
                e.act = en && live;
                exp_q.push_back(e);
            end
        endfunction

        // accepted output request: compare with oldest expectation
        function void check_output(t_out_byte got);
            t_out_byte e;
            if (exp_q.size() == 0) begin
                $error("unexpected output byte %02h", got.b);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (got.b !== e.b) begin
                $error("out_byte expected %02h actual %02h", e.b, got.b);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last_of_run expected %0b actual %0b", e.last, got.last);
                errors++;
            end
            if (got.act !== e.act) begin
                $error("filter_active expected %0b actual %0b", e.act, got.act);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk, i_rst_n, i_valid, i_packet_start, i_stall, i_cfg_valid, i_cfg_data;
    logic [7:0] i_data_byte;
    logic       o_stall, o_valid, o_last_of_run, o_filter_active, o_cfg_ready;
    logic [7:0] o_out_byte;

    strip_scoreboard sb = new();
    t_in_byte    stim_q[$];
    logic [12:0] known_pmt[$];
    logic [12:0] known_vid[$];
    bit          hold_go;

    ts_video_stream_stripper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_packet_start(i_packet_start),
        .o_valid(o_valid), .i_stall(i_stall), .o_out_byte(o_out_byte),
        .o_last_of_run(o_last_of_run), .o_filter_active(o_filter_active),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("ts_video_stream_stripper test failed");
        $finish;
    end

    // request monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_data_byte, i_packet_start);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_output('{b: o_out_byte, last: o_last_of_run, act: o_filter_active});
    end

    // receiver stall pattern, with one long hold-off
    int  rx_cyc, rx_mode, hold_cnt;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_cyc = 0; rx_mode = 0; hold_cnt = 0; hold_done = 0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 2);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (rx_mode == 0) i_stall <= 1'b0;
            else if (rx_mode == 1) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    // one transport packet, cut to len bytes, or by default to the header, body and up to four fillers
    task automatic push_pkt(bit ps, logic [12:0] pid, bit pusi, bit af, bit pl,
                            logic [7:0] body[$], int len = 0);
        logic [7:0] p[$];
        int n;
        int full;
        p.push_back(tsvs_pkg::SyncByte);
        p.push_back({1'($urandom), pusi, 1'($urandom), pid[12:8]});
        p.push_back(pid[7:0]);
        p.push_back({2'($urandom), af, pl, 4'($urandom)});
        if (af) begin
            n = $urandom_range(0, 6);
            p.push_back(8'(n));
            repeat (n) p.push_back(8'($urandom));
        end
        foreach (body[i]) p.push_back(body[i]);
        full = (len > 0) ? len : p.size() + $urandom_range(0, 4);
        if (full > tsvs_pkg::PacketBytes) full = tsvs_pkg::PacketBytes;
        while (p.size() < tsvs_pkg::PacketBytes)
            p.push_back($urandom_range(0, 3) ? 8'hFF : 8'($urandom));
        for (int i = 0; i < full; i++)
            stim_q.push_back('{b: p[i], ps: (i == 0) ? ps : 1'b0});
    endtask

    task automatic push_pat(logic [12:0] pids[$], bit prog0);
        logic [7:0] s[$];
        int slen;
        slen = 9 + 4 * (pids.size() + prog0);
        s = '{8'h00, 8'h00, 8'hB0 | 8'(slen >> 8), 8'(slen), 8'h00, 8'h01, 8'hC1, 8'h00, 8'h00};
        if (prog0) s = {s, 8'h00, 8'h00, 8'hE0, 8'h10};
        foreach (pids[i]) begin
            s = {s, 8'h00, 8'(i + 1), 8'hE0 | 8'(pids[i] >> 8), 8'(pids[i])};
            if (!(pids[i] inside {known_pmt})) known_pmt.push_back(pids[i]);
        end
        repeat (4) s.push_back(8'($urandom));
        push_pkt(1, 13'd0, 1, $urandom_range(0, 3) == 0, 1, s);
    endtask

    // pmt section with random streams; ptr, other-table and short-section options
    task automatic push_pmt(logic [12:0] pid, int ptr, bit other_first, bit short_sec);
        logic [7:0] s[$], es[$];
        logic [7:0] vtypes[$] = '{8'h01, 8'h02, 8'h10, 8'h1B, 8'h20, 8'h21,
                                  8'h24, 8'h42, 8'hD1, 8'hD2, 8'hEA};
        logic [7:0] otypes[$] = '{8'h03, 8'h0F, 8'h81, 8'h06, 8'h00, 8'hFF};
        logic [7:0] t;
        logic [12:0] ep;
        int pinfo, info, slen;
        s.push_back(8'(ptr));
        repeat (ptr) s.push_back(8'($urandom));
        if (other_first) s = {s, 8'h03, 8'hB0, 8'h03, 8'h11, 8'h22, 8'h33};
        if (short_sec)
            s = {s, tsvs_pkg::TidPmt, 8'hB0, 8'($urandom_range(0, 3)), 8'hAA, 8'h55, 8'h66};
        pinfo = $urandom_range(0, 3);
        repeat (pinfo) es.push_back(8'($urandom));
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) t = vtypes[$urandom_range(0, vtypes.size() - 1)];
            else t = otypes[$urandom_range(0, otypes.size() - 1)];
            ep = 13'h200 + 13'($urandom_range(0, 40));
            if (t inside {vtypes} && !(ep inside {known_vid})) known_vid.push_back(ep);
            info = $urandom_range(0, 4);
            es = {es, t, 8'hE0 | 8'(ep >> 8), 8'(ep), 8'hF0, 8'(info)};
            repeat (info) es.push_back(8'($urandom));
        end
        slen = 9 + es.size() + 4;
        s = {s, tsvs_pkg::TidPmt, 8'hB0 | 8'(slen >> 8), 8'(slen), 8'h00, 8'h01, 8'hC1,
             8'h00, 8'h00, 8'hE1, 8'h00, 8'hF0, 8'(pinfo)};
        s = {s, es};
        repeat (4) s.push_back(8'($urandom));
        s.push_back(tsvs_pkg::TidStop);
        push_pkt(1, pid, 1, $urandom_range(0, 3) == 0, 1, s);
    endtask

    task automatic push_random_pkts(int count);
        logic [7:0] body[$];
        logic [12:0] pl[$];
        int kind;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            body.delete();
            if (kind == 0 || known_pmt.size() == 0) begin
                pl.delete();
                repeat ($urandom_range(1, 4)) pl.push_back(13'h100 + 13'($urandom_range(0, 40)));
                push_pat(pl, $urandom_range(0, 1));
            end else if (kind <= 3)
                push_pmt(known_pmt[$urandom_range(0, known_pmt.size() - 1)],
                         $urandom_range(0, 1) ? 0 : $urandom_range(1, 5),
                         $urandom_range(0, 4) == 0, $urandom_range(0, 5) == 0);
            else if (kind <= 6 && known_vid.size() > 0)
                push_pkt($urandom_range(0, 5) != 0,
                         known_vid[$urandom_range(0, known_vid.size() - 1)],
                         $urandom_range(0, 1), $urandom_range(0, 1), 1, body);
            else if (kind == 7)
                push_pkt(1, 13'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), body, $urandom_range(1, 12));
            else
                push_pkt($urandom_range(0, 3) != 0, 13'($urandom), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1), body);
        end
    endtask

    // sender: bursts of requests with random gaps
    task automatic drive_stim();
        int burst;
        bit ok;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 80);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            i_valid <= 1'b1;
            i_data_byte <= stim_q[0].b;
            i_packet_start <= stim_q[0].ps;
            do begin
                @(negedge i_clk);
                ok = !o_stall;
                @(posedge i_clk);
            end while (!ok);
            void'(stim_q.pop_front());
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.exp_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(bit v);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        sb.en = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] body[$];
        i_rst_n = 0; i_valid = 0; i_data_byte = 0; i_packet_start = 0;
        i_cfg_valid = 0; i_cfg_data = 0; hold_go = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(1'b1);

        // directed: unaligned bytes, pat, pmt variants, nulled and passed pids
        stim_q.push_back('{b: 8'h00, ps: 1'b0});
        stim_q.push_back('{b: 8'hFF, ps: 1'b0});
        push_pat('{13'h100, 13'h101}, 1);
        push_pmt(13'h100, 0, 0, 0);
        push_pmt(13'h101, 3, 1, 1);
        body.delete();
        foreach (known_vid[i]) push_pkt(i % 2, known_vid[i], 0, 1, 1, body);
        push_pkt(1, 13'h0, 0, 1, 0, body);
        push_pkt(1, 13'h1FFF, 0, 0, 1, body, 2);
        push_pkt(1, 13'h0, 1, 0, 1, body, 20);
        drive_stim();
        wait_drained();

        // random, well-formed mostly, with a long receiver hold-off
        hold_go = 1;
        push_random_pkts(3);
        push_pkt(1, 13'h55, 0, 0, 1, body, 2);
        drive_stim();
        wait_drained();

        // disabled: held byte flushed, everything passes
        cfg_write(1'b0);
        repeat (30) stim_q.push_back('{b: 8'($urandom), ps: 1'($urandom)});
        push_random_pkts(1);
        drive_stim();
        wait_drained();

        // enabled again, tables kept; then sync loss
        cfg_write(1'b1);
        push_random_pkts(3);
        stim_q.push_back('{b: 8'h12, ps: 1'b1});
        push_random_pkts(1);
        drive_stim();
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("ts_video_stream_stripper test passed");
        else
            $display("ts_video_stream_stripper test failed");
        $finish;
    end
endmodule

// ----- ts_video_stream_stripper.f -----
rtl/core/tsvs_pkg.sv
rtl/core/tsvs_pid_tables.sv
rtl/core/tsvs_out_queue.sv
rtl/core/ts_video_stream_stripper.sv
sim/ts_video_stream_stripper_tb.sv
